/* rtl/core/audio_rate_drop_duplicate_unit_macros.svh */
// Assertion macros for the audio rate drop/duplicate unit.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef AUDIO_RATE_DROP_DUPLICATE_UNIT_MACROS_SVH
`define AUDIO_RATE_DROP_DUPLICATE_UNIT_MACROS_SVH

// Checked only outside reset.
`define ARDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ardd assertion failed");

// Checked in reset too.
`define ARDD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ardd reset assertion failed");

`endif

/* rtl/core/ardd_pkg.sv */
// Shared constants, types and helpers for the drop/duplicate unit.
// No dependencies.
package ardd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int SMP_W        = 16;
    localparam int PH_W         = 16;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_THR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT  = 2'd3;

    localparam logic [PH_W-1:0]  RST_PHASE_INC = 16'd1025;
    localparam logic [PH_W-1:0]  RST_PHASE_THR = 16'd25025;
    localparam logic [CNT_W-1:0] RST_CH_COUNT  = 4'd2;

    localparam logic MODE_DROP = 1'b0;
    localparam logic MODE_DUP  = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [PH_W-1:0] inc;
        logic [PH_W-1:0] thr;
        logic [CH_W-1:0] last_ch;
    } t_cfg;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [CH_W-1:0]         ch;
        logic                    drop;
        logic                    replay;
        logic [CH_W-1:0]         last_ch;
    } t_entry;

    typedef struct packed {
        logic replaying;
        logic out_valid;
    } t_back_sts;

    // Position of the last channel in a frame; zero counts as one channel.
    function automatic logic [CH_W-1:0] eff_last_ch(input logic [CNT_W-1:0] cnt);
        logic [CH_W-1:0] r;
        if (cnt == '0) begin
            r = '0;
        end else if (cnt > CNT_W'(MAX_CHANNELS)) begin
            r = CH_W'(MAX_CHANNELS - 1);
        end else begin
            r = CH_W'(cnt - CNT_W'(1));
        end
        return r;
    endfunction

endpackage

/* rtl/core/ardd_if.sv */
// Valid/ready channel interfaces: input samples, results, config writes.
// Depends on ardd_pkg.
interface ardd_smp_if import ardd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ardd_res_if import ardd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_sample;
    logic [CH_W-1:0]         channel_index;
    logic                    is_repeat;
    logic                    last_of_run;

    modport source (output valid, output out_sample, output channel_index,
                    output is_repeat, output last_of_run, input ready);
    modport sink   (input valid, input out_sample, input channel_index,
                    input is_repeat, input last_of_run, output ready);
endinterface

interface ardd_cfg_if import ardd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ardd_front.sv */
// Front end: frame counting, phase accumulation and per-beat classification.
// Depends on ardd_pkg and ardd_smp_if.
module ardd_front import ardd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    ardd_smp_if.sink         i_smp,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [PH_W-1:0] r_acc, n_acc;
    logic [CH_W-1:0] r_cnt, n_cnt;
    logic            r_drop, n_drop;
    logic            r_rep, n_rep;

    logic [PH_W-1:0] inc_sat;
    logic [PH_W:0]   sum, sub;
    logic            slip, first, last, cur_drop, cur_rep;
    logic [PH_W-1:0] acc_upd;

    assign inc_sat = (i_cfg.inc > i_cfg.thr) ? i_cfg.thr : i_cfg.inc;
    assign sum     = {1'b0, r_acc} + {1'b0, inc_sat};
    assign sub     = sum - {1'b0, i_cfg.thr};
    assign slip    = (i_cfg.thr != '0) && (sum > {1'b0, i_cfg.thr});

    always_comb begin
        if (i_cfg.thr == '0) begin
            acc_upd = '0;
        end else if (slip) begin
            acc_upd = (sub > {1'b0, i_cfg.thr}) ? i_cfg.thr : sub[PH_W-1:0];
        end else begin
            acc_upd = sum[PH_W-1:0];
        end
    end

    assign first    = (r_cnt == '0);
    assign last     = (r_cnt >= i_cfg.last_ch);
    assign cur_drop = first ? (slip && (i_cfg.mode == MODE_DROP)) : r_drop;
    assign cur_rep  = first ? (slip && (i_cfg.mode == MODE_DUP))  : r_rep;

    assign i_smp.ready = !i_q_full;
    assign o_push      = i_smp.valid && !i_q_full;

    assign o_entry.sample  = i_smp.sample;
    assign o_entry.ch      = r_cnt;
    assign o_entry.drop    = cur_drop;
    assign o_entry.replay  = last && cur_rep;
    assign o_entry.last_ch = i_cfg.last_ch;

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        n_rep  = r_rep;
        if (o_push) begin
            if (first) begin
                n_acc = acc_upd;
            end
            n_cnt  = last ? '0 : r_cnt + CH_W'(1);
            n_drop = cur_drop;
            n_rep  = cur_rep && !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_rep  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
            r_rep  <= n_rep;
        end
    end

endmodule

/* rtl/core/ardd_queue.sv */
// Short FIFO of classified beats between front and back ends.
// Depends on ardd_pkg.
module ardd_queue import ardd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

/* rtl/core/ardd_back.sv */
// Back end: frame store, pass-through and frame replay into the output register.
// Depends on ardd_pkg and ardd_res_if.
module ardd_back import ardd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    ardd_res_if.source o_res,
    output t_back_sts  o_sts
);

    logic signed [SMP_W-1:0] r_store [MAX_CHANNELS];

    logic                    r_ov;
    logic signed [SMP_W-1:0] r_smp;
    logic [CH_W-1:0]         r_ch;
    logic                    r_isrep, r_last;

    logic                    r_rep_act;
    logic [CH_W-1:0]         r_rep_idx, r_rep_end;

    logic adv;

    assign adv   = !r_ov || o_res.ready;
    assign o_pop = adv && !r_rep_act && i_q_valid;

    assign o_res.valid         = r_ov;
    assign o_res.out_sample    = r_smp;
    assign o_res.channel_index = r_ch;
    assign o_res.is_repeat     = r_isrep;
    assign o_res.last_of_run   = r_last;

    assign o_sts.replaying = r_rep_act;
    assign o_sts.out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_store[i_entry.ch] <= i_entry.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_rep_act) begin
                r_smp   <= r_store[r_rep_idx];
                r_ch    <= r_rep_idx;
                r_isrep <= 1'b1;
                r_last  <= (r_rep_idx == r_rep_end);
            end else begin
                r_smp   <= i_entry.sample;
                r_ch    <= i_entry.ch;
                r_isrep <= 1'b0;
                r_last  <= !i_entry.replay;
            end
        end
        if (o_pop && i_entry.replay) begin
            r_rep_end <= i_entry.last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_rep_act <= 1'b0;
            r_rep_idx <= '0;
        end else if (adv) begin
            if (r_rep_act) begin
                r_ov <= 1'b1;
                if (r_rep_idx == r_rep_end) begin
                    r_rep_act <= 1'b0;
                end
                r_rep_idx <= r_rep_idx + CH_W'(1);
            end else if (i_q_valid) begin
                r_ov      <= !i_entry.drop;
                r_rep_act <= i_entry.replay;
                r_rep_idx <= '0;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/audio_rate_drop_duplicate_unit.sv */
// Top level of the audio sample drop/duplicate rate converter.
// Depends on ardd_pkg, ardd_if, ardd_front, ardd_queue, ardd_back and the macro header.
//
// Interleaved 16-bit samples enter on i_smp; each frame advances a phase
// accumulator and a slipping frame is either withheld (mode 0) or replayed
// once from the frame store after its last sample (mode 1). The front end takes
// one sample per clock into a four-beat queue unless the queue is full; the back
// end moves one result beat per clock through its output register while the
// output port is ready. A sample gives zero or one result beat, and the last
// sample of a duplicated frame gives one plus the channel count, so sustained
// throughput is set by the output port: one beat per clock while it is ready.
// Config writes are accepted every cycle and must be made while the unit is idle.
`include "audio_rate_drop_duplicate_unit_macros.svh"
module audio_rate_drop_duplicate_unit import ardd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ardd_smp_if.sink   i_smp,
    ardd_res_if.source o_res,
    ardd_cfg_if.sink   i_cfg
);

    logic             r_mode;
    logic [PH_W-1:0]  r_inc, r_thr;
    logic [CNT_W-1:0] r_ch_cnt;

    t_cfg      cfg;
    t_entry    push_entry, head_entry;
    t_back_sts back_sts;
    logic      push, pop, q_full, q_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DROP;
            r_inc    <= RST_PHASE_INC;
            r_thr    <= RST_PHASE_THR;
            r_ch_cnt <= RST_CH_COUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:      r_mode   <= i_cfg.data[0];
                REG_PHASE_INC: r_inc    <= i_cfg.data[PH_W-1:0];
                REG_PHASE_THR: r_thr    <= i_cfg.data[PH_W-1:0];
                REG_CH_COUNT:  r_ch_cnt <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode    = r_mode;
    assign cfg.inc     = r_inc;
    assign cfg.thr     = r_thr;
    assign cfg.last_ch = eff_last_ch(r_ch_cnt);

    ardd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_smp    (i_smp),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    ardd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    ardd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_res     (o_res),
        .o_sts     (back_sts)
    );

    // A replay always follows a beat already sitting in the output register.
    `ARDD_ASSERT(a_replay_has_beat, back_sts.replaying |-> back_sts.out_valid)
    // Input stalls only on a full queue.
    `ARDD_ASSERT(a_stall_only_full, !i_smp.ready |-> q_full)
    // Nothing is popped while a replay owns the output.
    `ARDD_ASSERT(a_no_pop_in_replay, back_sts.replaying |-> !pop)
    `ARDD_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_res.valid)

endmodule

/* sim/testbench.sv */
// Self-checking bench for audio_rate_drop_duplicate_unit: drop and repeat of
// interleaved PCM frames, checked beat by beat against an in-bench predictor.
// Depends on ardd_pkg, ardd_if and the unit's RTL.
module testbench import ardd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN       = 16;
    localparam int SUB_PHASES  = 4;
    localparam int SUB_ITEMS   = 21;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic [CH_W-1:0]         ch;
        logic                    rep;
        logic                    last;
    } t_pcm_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ardd_smp_if smp_ch ();
    ardd_res_if res_ch ();
    ardd_cfg_if cfg_ch ();

    audio_rate_drop_duplicate_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // register mirror
    logic             m_mode  = MODE_DROP;
    logic [PH_W-1:0]  m_inc   = RST_PHASE_INC;
    logic [PH_W-1:0]  m_thr   = RST_PHASE_THR;
    logic [CNT_W-1:0] m_count = RST_CH_COUNT;

    // converter state
    logic [PH_W-1:0]         phase_acc  = '0;
    int unsigned             frame_pos  = 0;
    logic signed [SMP_W-1:0] frame_buf [MAX_CHANNELS];
    logic                    drop_frame = 1'b0;
    logic                    replay_due = 1'b0;

    t_pcm_beat               due_beats [$];
    logic signed [SMP_W-1:0] pending [$];
    logic smp_took    = 1'b0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    logic hold_arm    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cnt    = 0;
    int   idle_cycles = 0;
    int   fail_count  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void advance_rate_converter(input logic signed [SMP_W-1:0] s);
        t_pcm_beat       run [MAX_CHANNELS+1];
        int unsigned     n;
        int unsigned     k;
        logic [PH_W:0]   sum;
        logic [PH_W-1:0] step;
        logic            slip;
        k = 0;
        if (m_count == '0) begin
            n = 1;
        end else if (m_count > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end else begin
            n = 32'(m_count);
        end
        if (frame_pos == 0) begin
            slip = 1'b0;
            if (m_thr == '0) begin
                phase_acc = '0;
            end else begin
                step = (m_inc > m_thr) ? m_thr : m_inc;
                sum  = {1'b0, phase_acc} + {1'b0, step};
                if (sum > {1'b0, m_thr}) begin
                    slip = 1'b1;
                    sum  = sum - {1'b0, m_thr};
                    if (sum > {1'b0, m_thr}) begin
                        sum = {1'b0, m_thr};
                    end
                end
                phase_acc = sum[PH_W-1:0];
            end
            drop_frame = slip && (m_mode == MODE_DROP);
            replay_due = slip && (m_mode == MODE_DUP);
        end
        frame_buf[frame_pos] = s;
        if (!drop_frame) begin
            run[k] = '{s, CH_W'(frame_pos), 1'b0, 1'b0};
            k++;
        end
        if (frame_pos + 1 >= n) begin
            if (replay_due) begin
                for (int i = 0; i < n; i++) begin
                    run[k] = '{frame_buf[i], CH_W'(i), 1'b1, 1'b0};
                    k++;
                end
            end
            frame_pos  = 0;
            replay_due = 1'b0;
        end else begin
            frame_pos++;
        end
        if (k > 0) begin
            run[k-1].last = 1'b1;
        end
        for (int i = 0; i < k; i++) begin
            due_beats.push_back(run[i]);
        end
    endfunction

    // sample driver
    always @(negedge i_clk) begin : drv
        logic                    nv;
        logic signed [SMP_W-1:0] ns;
        nv = smp_ch.valid;
        ns = smp_ch.sample;
        if (smp_took) begin
            void'(pending.pop_front());
            smp_took = 1'b0;
            nv = 1'b0;
        end
        if (!nv && pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            nv = 1'b1;
            ns = pending[0];
        end
        smp_ch.valid  <= nv;
        smp_ch.sample <= ns;
    end

    // result sink, with one long hold-off once armed
    always @(negedge i_clk) begin : snk
        logic r;
        if (hold_arm && !hold_done && hold_cnt < HOLD_LEN) begin
            r = 1'b0;
            hold_cnt++;
        end else begin
            if (hold_arm) begin
                hold_done = 1'b1;
            end
            r = ($urandom_range(99) >= snk_idle_pct);
        end
        res_ch.ready <= r;
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin : mon
        t_pcm_beat want;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (smp_ch.valid && smp_ch.ready) begin
                advance_rate_converter(smp_ch.sample);
                smp_took = 1'b1;
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                if (due_beats.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected beat smp=%0d ch=%0d rep=%0b last=%0b",
                             $time, res_ch.out_sample, res_ch.channel_index,
                             res_ch.is_repeat, res_ch.last_of_run);
                end else begin
                    want = due_beats.pop_front();
                    if (want.smp !== res_ch.out_sample || want.ch !== res_ch.channel_index ||
                        want.rep !== res_ch.is_repeat || want.last !== res_ch.last_of_run) begin
                        fail_count++;
                        $display("%0t ns: mismatch, expected smp=%0d ch=%0d rep=%0b last=%0b",
                                 $time, want.smp, want.ch, want.rep, want.last);
                        $display("%0t ns:           got smp=%0d ch=%0d rep=%0b last=%0b",
                                 $time, res_ch.out_sample, res_ch.channel_index,
                                 res_ch.is_repeat, res_ch.last_of_run);
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic settle();
        while (pending.size() != 0 || smp_ch.valid || due_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_MODE:      m_mode  = val[0];
            REG_PHASE_INC: m_inc   = val[PH_W-1:0];
            REG_PHASE_THR: m_thr   = val[PH_W-1:0];
            REG_CH_COUNT:  m_count = val[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stim
        logic [PH_W-1:0] thr;
        logic [PH_W-1:0] inc;
        logic [CNT_W-1:0] cnt;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_MODE;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 18;
        snk_idle_pct = 55;

        // every frame after the first slips; extremes of the sample range
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DUP));
        write_reg(REG_PHASE_INC, 16'hFFFF);
        write_reg(REG_PHASE_THR, 16'd100);
        write_reg(REG_CH_COUNT, 16'd3);
        pending.push_back(16'sh7FFF); pending.push_back(16'sh8000); pending.push_back(16'sh0000);
        pending.push_back(16'shFFFF); pending.push_back(16'sh0001); pending.push_back(16'sh5555);
        settle();
        // channel count lowered mid-frame
        pending.push_back(16'sh1234);
        settle();
        write_reg(REG_CH_COUNT, 16'd1);
        pending.push_back(16'sh4321);
        settle();
        // zero channels counts as one
        write_reg(REG_CH_COUNT, 16'd0);
        pending.push_back(16'shAAAA); pending.push_back(16'sh2AAA);
        settle();
        // oversized count saturates; mode flipped mid-frame keeps the latched repeat
        write_reg(REG_CH_COUNT, 16'd15);
        pending.push_back(16'sh0101); pending.push_back(16'sh0202); pending.push_back(16'sh0303);
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DROP));
        pending.push_back(16'sh0404); pending.push_back(16'sh0505); pending.push_back(16'sh0606);
        pending.push_back(16'sh0707); pending.push_back(16'sh0808);
        settle();
        // slipping frames withheld
        write_reg(REG_CH_COUNT, 16'd2);
        pending.push_back(16'sh1111); pending.push_back(16'sh2222);
        pending.push_back(16'sh3333); pending.push_back(16'sh4444);
        settle();
        // zero threshold holds the accumulator at zero
        write_reg(REG_PHASE_THR, 16'd0);
        pending.push_back(16'sh7FFE); pending.push_back(16'sh8001);
        settle();
        // accumulator left above a lowered threshold
        write_reg(REG_PHASE_THR, 16'd60000);
        write_reg(REG_PHASE_INC, 16'd60000);
        write_reg(REG_CH_COUNT, 16'd1);
        pending.push_back(16'sh0F0F); pending.push_back(16'shF0F0);
        settle();
        write_reg(REG_PHASE_THR, 16'd1000);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DUP));
        pending.push_back(16'sh00FF); pending.push_back(16'shFF00);

        for (int prof = 0; prof < 3; prof++) begin
            for (int sub = 0; sub < SUB_PHASES; sub++) begin
                settle();
                case ($urandom_range(7))
                    0: thr = '0;
                    1: thr = 16'd1;
                    2: thr = 16'hFFFF;
                    default: thr = PH_W'($urandom_range(65535, 16));
                endcase
                case ($urandom_range(5))
                    0: inc = '0;
                    1: inc = 16'hFFFF;
                    2: inc = thr;
                    default: inc = PH_W'($urandom_range(thr, thr / 4));
                endcase
                case ($urandom_range(9))
                    0: cnt = '0;
                    1: cnt = CNT_W'($urandom_range(15, MAX_CHANNELS + 1));
                    default: cnt = CNT_W'($urandom_range(MAX_CHANNELS, 1));
                endcase
                write_reg(REG_MODE, CFG_DATA_W'($urandom_range(1)));
                write_reg(REG_PHASE_INC, inc);
                write_reg(REG_PHASE_THR, thr);
                write_reg(REG_CH_COUNT, CFG_DATA_W'(cnt));
                if (prof == 2 && sub == 0) begin
                    hold_arm = 1'b1;
                end
                for (int i = 0; i < SUB_ITEMS; i++) begin
                    case ($urandom_range(15))
                        0: pending.push_back(16'sh7FFF);
                        1: pending.push_back(16'sh8000);
                        default: pending.push_back(SMP_W'($urandom));
                    endcase
                end
            end
            settle();
            if (prof == 0) begin
                src_idle_pct = 55;
                snk_idle_pct = 18;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        end

        settle();
        if (fail_count == 0 && due_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
